[design/fct_pkg.sv]
// Shared types, codes and constants of the fan coil thermostat.
package fct_pkg;

  // Field widths of the request and result items, the configuration and the timers.
  localparam int unsigned ModeW     = 6;
  localparam int unsigned SetptW    = 4;
  localparam int unsigned FanW      = 2;
  localparam int unsigned TempW     = 8;
  localparam int unsigned CfgW      = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RelayCntW = 3;
  localparam int unsigned FanCntW   = 8;
  // Tenths-of-a-degree values span -1590 to 1279, so 12 signed bits suffice.
  localparam int unsigned TenthsW   = 12;

  // Unit mode codes. Any even code means off.
  localparam logic [ModeW-1:0] MODE_FAN  = 6'd1;
  localparam logic [ModeW-1:0] MODE_COOL = 6'd17;
  localparam logic [ModeW-1:0] MODE_HEAT = 6'd33;
  localparam logic [ModeW-1:0] MODE_AUTO = 6'd49;

  // Request opcodes.
  localparam logic OP_SETTINGS = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Fan setting that hands the speed to the automatic check.
  localparam logic [FanW-1:0] FAN_AUTO = 2'd0;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_STEP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_STEP = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FAN_PERIOD = 2'd3;

  // Configuration reset values.
  localparam logic [CfgW-1:0] HYSTERESIS_RST  = 8'd10;
  localparam logic [CfgW-1:0] FIRST_STEP_RST  = 8'd5;
  localparam logic [CfgW-1:0] SECOND_STEP_RST = 8'd20;
  localparam logic [CfgW-1:0] FAN_PERIOD_RST  = 8'd30;

  // Setpoint index offset in whole degrees, and the tenths scale.
  localparam logic [TenthsW-1:0] SETPOINT_BASE = 12'd16;
  localparam logic [TenthsW-1:0] TENTHS_SCALE  = 12'd10;

  // Default number of ticks between relay checks.
  localparam int unsigned RELAY_PERIOD_DEF = 5;

  typedef struct packed {
    logic              opcode;
    logic [ModeW-1:0]  mode_code;
    logic [SetptW-1:0] setpoint_index;
    logic [FanW-1:0]   fan_setting;
    logic [TempW-1:0]  temp_whole;
    logic [TempW-1:0]  temp_frac;
  } fct_item_t;

  typedef struct packed {
    logic            heat_on;
    logic            cool_on;
    logic [FanW-1:0] fan_speed;
  } fct_result_t;

  typedef struct packed {
    logic [CfgW-1:0] hysteresis;
    logic [CfgW-1:0] first_step;
    logic [CfgW-1:0] second_step;
    logic [CfgW-1:0] fan_period;
  } fct_cfg_t;

endpackage

[design/fct_stream_if.sv]
// Valid/ready stream channel carrying one payload type.
interface fct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/fct_ctrl.sv]
// Thermostat state and the per-request relay and fan decision logic.
module fct_ctrl
  import fct_pkg::*;
#(
  parameter int unsigned RELAY_PERIOD = RELAY_PERIOD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  fct_item_t   item_i,
  input  fct_cfg_t    cfg_i,
  output fct_result_t result_o
);

  localparam logic [RelayCntW-1:0] RelayReload = RelayCntW'(RELAY_PERIOD);

  logic                 heat_q, heat_d;
  logic                 cool_q, cool_d;
  logic [FanW-1:0]      fan_q, fan_d;
  logic [ModeW-1:0]     mode_q, mode_d;
  logic [SetptW-1:0]    setpt_q, setpt_d;
  logic                 relay_on_q, relay_on_d;
  logic [RelayCntW-1:0] relay_cnt_q, relay_cnt_d;
  logic                 fan_on_q, fan_on_d;
  logic [FanCntW-1:0]   fan_cnt_q, fan_cnt_d;

  logic [ModeW-1:0]          sel_mode;
  logic [SetptW-1:0]         sel_setpt;
  logic [TenthsW-1:0]        frac_x10;
  logic signed [TenthsW-1:0] room_t;
  logic [TenthsW-1:0]        set_t;
  logic signed [TenthsW-1:0] delta;
  logic signed [TenthsW-1:0] hyst_s, step1_s, step2_s;
  logic [FanCntW-1:0]        fan_reload;
  logic [RelayCntW-1:0]      relay_dec;
  logic [FanCntW-1:0]        fan_dec;
  logic                      is_relay_mode;

  // Fan check: picks a speed from the error, or keeps the one given.
  function automatic logic [FanW-1:0] fan_check(
    input logic [ModeW-1:0]          mode,
    input logic [FanW-1:0]           level,
    input logic signed [TenthsW-1:0] d,
    input logic signed [TenthsW-1:0] s1,
    input logic signed [TenthsW-1:0] s2
  );
    logic [FanW-1:0] res;
    res = level;
    if (mode == MODE_COOL) begin
      if (d >= s2) res = 2'd2;
      else if (d >= s1) res = 2'd1;
      else if (d <= 0) res = 2'd0;
    end else if (mode == MODE_HEAT) begin
      if (d <= -s2) res = 2'd2;
      else if (d <= -s1) res = 2'd1;
      else if (d >= 0) res = 2'd0;
    end
    return res;
  endfunction

  // Updates use the new mode and setpoint, ticks the stored ones.
  assign sel_mode  = (item_i.opcode == OP_SETTINGS) ? item_i.mode_code : mode_q;
  assign sel_setpt = (item_i.opcode == OP_SETTINGS) ? item_i.setpoint_index : setpt_q;

  // Room and setpoint temperatures in tenths, and their difference.
  assign frac_x10 = TenthsW'(item_i.temp_frac) * TENTHS_SCALE;
  assign room_t   = $signed({{(TenthsW-TempW){item_i.temp_whole[TempW-1]}},
                             item_i.temp_whole}) * $signed(TENTHS_SCALE)
                    + $signed({{(TenthsW-4){1'b0}}, frac_x10[TenthsW-1:TenthsW-4]});
  assign set_t    = (TenthsW'(sel_setpt) + SETPOINT_BASE) * TENTHS_SCALE;
  assign delta    = room_t - $signed(set_t);

  assign hyst_s  = $signed(TenthsW'(cfg_i.hysteresis));
  assign step1_s = $signed(TenthsW'(cfg_i.first_step));
  assign step2_s = $signed(TenthsW'(cfg_i.second_step));

  assign fan_reload    = (cfg_i.fan_period == '0) ? FanCntW'(1) : cfg_i.fan_period;
  assign relay_dec     = relay_cnt_q - RelayCntW'(1);
  assign fan_dec       = fan_cnt_q - FanCntW'(1);
  assign is_relay_mode = (sel_mode == MODE_COOL) || (sel_mode == MODE_HEAT) ||
                         (sel_mode == MODE_AUTO);

  // Next state for one request.
  always_comb begin
    heat_d      = heat_q;
    cool_d      = cool_q;
    fan_d       = fan_q;
    mode_d      = mode_q;
    setpt_d     = setpt_q;
    relay_on_d  = relay_on_q;
    relay_cnt_d = relay_cnt_q;
    fan_on_d    = fan_on_q;
    fan_cnt_d   = fan_cnt_q;
    if (item_i.opcode == OP_SETTINGS) begin
      mode_d  = item_i.mode_code;
      setpt_d = item_i.setpoint_index;
      if (item_i.mode_code[0]) begin
        if (item_i.mode_code == MODE_FAN) begin
          relay_on_d = 1'b0;
          heat_d     = 1'b0;
          cool_d     = 1'b0;
        end else if (is_relay_mode) begin
          // Start rule.
          if (delta > 0 && (sel_mode == MODE_COOL || sel_mode == MODE_AUTO)) begin
            heat_d = 1'b0;
            cool_d = 1'b1;
          end else if (delta < 0 &&
                       (sel_mode == MODE_HEAT || sel_mode == MODE_AUTO)) begin
            heat_d = 1'b1;
            cool_d = 1'b0;
          end else begin
            heat_d = 1'b0;
            cool_d = 1'b0;
          end
          relay_on_d  = 1'b1;
          relay_cnt_d = RelayReload;
        end
        fan_on_d = 1'b0;
        if (item_i.fan_setting != FAN_AUTO) begin
          fan_d = item_i.fan_setting;
        end else begin
          fan_d     = fan_check(sel_mode, 2'd1, delta, step1_s, step2_s);
          fan_on_d  = 1'b1;
          fan_cnt_d = fan_reload;
        end
      end else begin
        // Off mode.
        relay_on_d = 1'b0;
        fan_on_d   = 1'b0;
        heat_d     = 1'b0;
        cool_d     = 1'b0;
        fan_d      = '0;
      end
    end else begin
      // Relay timer and the relay check with hysteresis.
      if (relay_on_q) begin
        relay_cnt_d = relay_dec;
        if (relay_dec == '0) begin
          relay_cnt_d = RelayReload;
          if ((heat_q && sel_mode == MODE_HEAT && delta >= 0) ||
              (cool_q && sel_mode == MODE_COOL && delta <= 0) ||
              (sel_mode == MODE_AUTO &&
               ((heat_q && delta >= 0) || (cool_q && delta <= 0)))) begin
            heat_d = 1'b0;
            cool_d = 1'b0;
          end else if (delta > hyst_s &&
                       (sel_mode == MODE_COOL || sel_mode == MODE_AUTO)) begin
            heat_d = 1'b0;
            cool_d = 1'b1;
          end else if (delta < -hyst_s &&
                       (sel_mode == MODE_HEAT || sel_mode == MODE_AUTO)) begin
            heat_d = 1'b1;
            cool_d = 1'b0;
          end
        end
      end
      // Fan timer and the periodic fan check.
      if (fan_on_q) begin
        fan_cnt_d = fan_dec;
        if (fan_dec == '0) begin
          fan_d     = fan_check(sel_mode, fan_q, delta, step1_s, step2_s);
          fan_cnt_d = fan_reload;
        end
      end
    end
  end

  // State registers, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q      <= 1'b0;
      cool_q      <= 1'b0;
      fan_q       <= '0;
      mode_q      <= '0;
      setpt_q     <= '0;
      relay_on_q  <= 1'b0;
      relay_cnt_q <= '0;
      fan_on_q    <= 1'b0;
      fan_cnt_q   <= '0;
    end else if (step_i) begin
      heat_q      <= heat_d;
      cool_q      <= cool_d;
      fan_q       <= fan_d;
      mode_q      <= mode_d;
      setpt_q     <= setpt_d;
      relay_on_q  <= relay_on_d;
      relay_cnt_q <= relay_cnt_d;
      fan_on_q    <= fan_on_d;
      fan_cnt_q   <= fan_cnt_d;
    end
  end

  assign result_o.heat_on   = heat_d;
  assign result_o.cool_on   = cool_d;
  assign result_o.fan_speed = fan_d;

endmodule

[design/fan_coil_thermostat.sv]
// Top level of the fan coil thermostat: handshakes, configuration and pipeline.
//
//   Channel   Direction  Handshake        Payload
//   in_if     sink       valid / ready    fct_item_t (opcode, mode, setpoint, fan, temp)
//   out_if    source     valid / ready    fct_result_t (heat_on, cool_on, fan_speed)
//   cfg       write      cfg_we_i         cfg_idx_i, cfg_data_i
//
// One request is accepted per cycle while the output side keeps taking results; it is
// held in the input register, then in the result register until it is taken.
// The limit is the single state update in fct_ctrl, which is computed combinationally.
// Reset clears the relays, fan, timers and mode and loads the register defaults.
// A stalled output holds its result while one more request waits in the input stage.
module fan_coil_thermostat
  import fct_pkg::*;
#(
  parameter int unsigned RELAY_PERIOD = RELAY_PERIOD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fct_stream_if.sink         in_if,
  fct_stream_if.source       out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  fct_cfg_t    cfg_q;
  logic        in_vld_q;
  fct_item_t   in_item_q;
  logic        out_vld_q;
  fct_result_t out_res_q;
  fct_result_t res_next;
  logic        advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis  <= HYSTERESIS_RST;
      cfg_q.first_step  <= FIRST_STEP_RST;
      cfg_q.second_step <= SECOND_STEP_RST;
      cfg_q.fan_period  <= FAN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HYSTERESIS:  cfg_q.hysteresis  <= cfg_data_i;
        CFG_FIRST_STEP:  cfg_q.first_step  <= cfg_data_i;
        CFG_SECOND_STEP: cfg_q.second_step <= cfg_data_i;
        CFG_FAN_PERIOD:  cfg_q.fan_period  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or being emptied.
  assign advance     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_item_q <= in_if.payload;
    end
  end

  fct_ctrl #(
    .RELAY_PERIOD(RELAY_PERIOD)
  ) u_fct_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(res_next)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_next;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_res_q;

endmodule

[design/fct_checker.sv]
// Port-level checks of the fan coil thermostat and their binding.
module fct_checker
  import fct_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input fct_result_t out_res_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_res_i))
    else $error("output payload changed while stalled");

  // The heat and cool relays are never driven together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_res_i.heat_on && out_res_i.cool_on))
    else $error("heat and cool relays both on");

  // An accepted request reaches the output once the output side takes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("accepted request produced no result");

endmodule

bind fan_coil_thermostat fct_checker u_fct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_res_i  (out_if.payload)
);

[bench/tb.sv]
// Self-checking testbench for the fan coil thermostat: random and directed requests, scoreboard.
module tb import fct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes with no name in the package: off codes and odd codes the unit does not know.
  localparam logic [ModeW-1:0] MODE_OFF      = 6'd0;
  localparam logic [ModeW-1:0] MODE_OFF_HIGH = 6'd62;
  localparam logic [ModeW-1:0] MODE_ODD_ALL  = 6'd63;
  localparam logic [ModeW-1:0] MODE_ODD_MID  = 6'd35;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 120;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_style_e;

  // Predicts the relay and fan drives and checks them against what the block returns.
  class heat_cool_scoreboard;
    logic [CfgW-1:0]      hyst_band, first_step, second_step, fan_period;
    logic                 heat_relay, cool_relay;
    logic [FanW-1:0]      fan_level;
    logic [ModeW-1:0]     unit_mode;
    logic [SetptW-1:0]    setpoint_idx;
    logic                 relay_timer_on, fan_timer_on;
    logic [RelayCntW-1:0] relay_count;
    logic [FanCntW-1:0]   fan_count;
    fct_result_t          pending_drives[$];
    int                   n_checked;
    int                   n_failures;

    function new();
      hyst_band      = HYSTERESIS_RST;
      first_step     = FIRST_STEP_RST;
      second_step    = SECOND_STEP_RST;
      fan_period     = FAN_PERIOD_RST;
      heat_relay     = 1'b0;
      cool_relay     = 1'b0;
      fan_level      = '0;
      unit_mode      = MODE_OFF;
      setpoint_idx   = '0;
      relay_timer_on = 1'b0;
      fan_timer_on   = 1'b0;
      relay_count    = '0;
      fan_count      = '0;
      n_checked      = 0;
      n_failures     = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_HYSTERESIS:  hyst_band = val;
        CFG_FIRST_STEP:  first_step = val;
        CFG_SECOND_STEP: second_step = val;
        CFG_FAN_PERIOD:  fan_period = val;
        default: ;
      endcase
    endfunction

    // Room temperature in tenths: whole degrees plus the truncated tenths of the fraction.
    function int room_tenths(fct_item_t it);
      int whole;
      whole = $signed(it.temp_whole);
      return whole * 10 + ((int'(it.temp_frac) * 10) >>> 8);
    endfunction

    function int setpoint_tenths();
      return (int'(setpoint_idx) + 16) * 10;
    endfunction

    function logic [FanCntW-1:0] fan_reload();
      return (fan_period == '0) ? FanCntW'(1) : fan_period;
    endfunction

    function void set_relays(logic heat, logic cool);
      heat_relay = heat;
      cool_relay = cool;
    endfunction

    function bit cools();
      return unit_mode == MODE_COOL || unit_mode == MODE_AUTO;
    endfunction

    function bit heats();
      return unit_mode == MODE_HEAT || unit_mode == MODE_AUTO;
    endfunction

    // Relays as a settings update leaves them, from the room minus setpoint difference.
    function void start_rule(int diff);
      if (diff > 0 && cools()) begin
        set_relays(1'b0, 1'b1);
      end else if (diff < 0 && heats()) begin
        set_relays(1'b1, 1'b0);
      end else begin
        set_relays(1'b0, 1'b0);
      end
    endfunction

    // Periodic relay check: stop at the setpoint, re-engage beyond the hysteresis band.
    function void relay_check(int diff);
      int band;
      band = int'(hyst_band);
      if (heat_relay && unit_mode == MODE_HEAT && diff >= 0) begin
        set_relays(1'b0, 1'b0);
      end else if (cool_relay && unit_mode == MODE_COOL && diff <= 0) begin
        set_relays(1'b0, 1'b0);
      end else if (unit_mode == MODE_AUTO &&
                   ((heat_relay && diff >= 0) || (cool_relay && diff <= 0))) begin
        set_relays(1'b0, 1'b0);
      end else if (diff > band && cools()) begin
        set_relays(1'b0, 1'b1);
      end else if (diff < -band && heats()) begin
        set_relays(1'b1, 1'b0);
      end
    endfunction

    // Automatic fan speed from the setpoint minus room error; other modes keep the speed.
    function void fan_check(int err);
      int step1, step2;
      step1 = int'(first_step);
      step2 = int'(second_step);
      if (unit_mode == MODE_COOL) begin
        if (err <= -step2) fan_level = 2'd2;
        else if (err <= -step1) fan_level = 2'd1;
        else if (err >= 0) fan_level = 2'd0;
      end else if (unit_mode == MODE_HEAT) begin
        if (err >= step2) fan_level = 2'd2;
        else if (err >= step1) fan_level = 2'd1;
        else if (err <= 0) fan_level = 2'd0;
      end
    endfunction

    // Applies one accepted request and queues the drives it leaves behind.
    function void apply_request(fct_item_t it);
      int          room;
      fct_result_t drive;
      room = room_tenths(it);
      if (it.opcode == OP_SETTINGS) begin
        unit_mode    = it.mode_code;
        setpoint_idx = it.setpoint_index;
        if (unit_mode[0]) begin
          if (unit_mode == MODE_FAN) begin
            relay_timer_on = 1'b0;
            set_relays(1'b0, 1'b0);
          end else if (unit_mode == MODE_COOL || unit_mode == MODE_HEAT ||
                       unit_mode == MODE_AUTO) begin
            start_rule(room - setpoint_tenths());
            relay_timer_on = 1'b1;
            relay_count    = RelayCntW'(RELAY_PERIOD_DEF);
          end
          fan_timer_on = 1'b0;
          if (it.fan_setting != FAN_AUTO) begin
            fan_level = it.fan_setting;
          end else begin
            fan_level = 2'd1;
            fan_check(setpoint_tenths() - room);
            fan_timer_on = 1'b1;
            fan_count    = fan_reload();
          end
        end else begin
          relay_timer_on = 1'b0;
          fan_timer_on   = 1'b0;
          set_relays(1'b0, 1'b0);
          fan_level = '0;
        end
      end else begin
        if (relay_timer_on) begin
          relay_count = relay_count - RelayCntW'(1);
          if (relay_count == '0) begin
            relay_check(room - setpoint_tenths());
            relay_count = RelayCntW'(RELAY_PERIOD_DEF);
          end
        end
        if (fan_timer_on) begin
          fan_count = fan_count - FanCntW'(1);
          if (fan_count == '0) begin
            fan_check(setpoint_tenths() - room);
            fan_count = fan_reload();
          end
        end
      end
      drive.heat_on   = heat_relay;
      drive.cool_on   = cool_relay;
      drive.fan_speed = fan_level;
      pending_drives.push_back(drive);
    endfunction

    // Compares one returned drive set with the oldest prediction.
    function void check_result(fct_result_t got);
      fct_result_t want;
      if (pending_drives.size() == 0) begin
        n_failures++;
        if (n_failures <= 10)
          $display("mismatch: drives %p returned with no request outstanding", got);
        return;
      end
      want = pending_drives.pop_front();
      n_checked++;
      if (got.heat_on !== want.heat_on || got.cool_on !== want.cool_on ||
          got.fan_speed !== want.fan_speed) begin
        n_failures++;
        if (n_failures <= 10)
          $display({"mismatch at result %0d: expected heat %0b cool %0b fan %0d, ",
                    "got heat %0b cool %0b fan %0d"},
                   n_checked, want.heat_on, want.cool_on, want.fan_speed,
                   got.heat_on, got.cool_on, got.fan_speed);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  fct_stream_if #(.payload_t(fct_item_t))   req_if ();
  fct_stream_if #(.payload_t(fct_result_t)) drive_if ();

  fan_coil_thermostat DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_if),
    .out_if     (drive_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  heat_cool_scoreboard sb = new();

  rx_style_e rx_style    = RX_STEADY;
  int        hold_len    = 0;
  bit        gaps_on     = 1'b1;
  int        burst_left  = 0;
  int        n_sent      = 0;
  int        n_updates   = 0;
  int        n_ticks     = 0;

  always #6ns clk_i = ~clk_i;

  // Accepted requests feed the predictor; accepted drives are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.apply_request(req_if.payload);
        if (req_if.payload.opcode == OP_SETTINGS) n_updates++;
        else n_ticks++;
      end
      if (drive_if.valid && drive_if.ready) sb.check_result(drive_if.payload);
    end
  end

  // Result side: steady, random or patterned stalls, and long hold-offs on request.
  initial begin
    int rx_count;
    rx_count = 0;
    drive_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_count++;
      if (hold_len > 0) begin
        drive_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        case (rx_style)
          RX_STEADY:  drive_if.ready <= 1'b1;
          RX_RANDOM:  drive_if.ready <= ($urandom_range(0, 9) >= 3);
          RX_PATTERN: drive_if.ready <= (rx_count % 7 != 2) && (rx_count % 7 != 3);
          default:    drive_if.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (drive_if.valid && drive_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic fct_item_t make_request(logic op, logic [ModeW-1:0] mode,
                                             logic [SetptW-1:0] sp, logic [FanW-1:0] fan,
                                             int temp_q);
    fct_item_t it;
    it.opcode         = op;
    it.mode_code      = mode;
    it.setpoint_index = sp;
    it.fan_setting    = fan;
    it.temp_whole     = temp_q[15:8];
    it.temp_frac      = temp_q[7:0];
    return it;
  endfunction

  // Offers one request in bursts separated by random gaps, holding it until accepted.
  task automatic send_request(input fct_item_t it);
    if (gaps_on && burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    n_sent++;
  endtask

  // A tick with random content in the fields that a tick ignores.
  task automatic send_tick(input int temp_q);
    send_request(make_request(OP_TICK, ModeW'($urandom_range(0, 63)),
                              SetptW'($urandom_range(0, 15)),
                              FanW'($urandom_range(0, 3)), temp_q));
  endtask

  // Stops offering and waits for every predicted drive to come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_register(idx, val);
  endtask

  task automatic load_settings(input logic [CfgW-1:0] hyst, input logic [CfgW-1:0] step1,
                               input logic [CfgW-1:0] step2, input logic [CfgW-1:0] period);
    write_register(CFG_HYSTERESIS, hyst);
    write_register(CFG_FIRST_STEP, step1);
    write_register(CFG_SECOND_STEP, step2);
    write_register(CFG_FAN_PERIOD, period);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One settings update followed by ticks while the room drifts around the setpoint.
  task automatic run_session(input int n_steps);
    logic [ModeW-1:0]  mode;
    logic [SetptW-1:0] sp;
    logic [FanW-1:0]   fan;
    int                pick, temp_q, drift;
    pick = $urandom_range(0, 19);
    if (pick < 5) mode = MODE_COOL;
    else if (pick < 10) mode = MODE_HEAT;
    else if (pick < 15) mode = MODE_AUTO;
    else if (pick < 17) mode = MODE_FAN;
    else if (pick < 18) mode = {5'($urandom_range(0, 31)), 1'b0};
    else mode = ModeW'($urandom_range(0, 63));
    sp     = SetptW'($urandom_range(0, 15));
    fan    = $urandom_range(0, 1) ? FAN_AUTO : FanW'($urandom_range(1, 3));
    temp_q = (16 + int'(sp)) * 256 + int'($urandom_range(0, 1536)) - 768;
    drift  = int'($urandom_range(0, 40)) - 20;
    send_request(make_request(OP_SETTINGS, mode, sp, fan, temp_q));
    repeat (n_steps) begin
      temp_q = temp_q + int'($urandom_range(0, 60)) - 30 + drift;
      if (temp_q > 32767) temp_q = 32767;
      if (temp_q < -32768) temp_q = -32768;
      send_tick(temp_q);
    end
  endtask

  // Requests with every field random, the temperature over its whole range.
  task automatic send_noise(input int count);
    repeat (count)
      send_request(make_request(1'($urandom_range(0, 1)), ModeW'($urandom_range(0, 63)),
                                SetptW'($urandom_range(0, 15)),
                                FanW'($urandom_range(0, 3)),
                                int'($urandom_range(0, 65535)) - 32768));
  endtask

  initial begin
    int  phase_start;
    bit  paused;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_HYSTERESIS;
    cfg_data_i     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset register values.
    send_request(make_request(OP_SETTINGS, MODE_OFF, 4'd0, FAN_AUTO, 127 * 256 + 255));
    send_request(make_request(OP_TICK, MODE_OFF, 4'd0, FAN_AUTO, -128 * 256));
    send_request(make_request(OP_SETTINGS, MODE_FAN, 4'd15, 2'd3, -128 * 256));
    // Unknown odd mode with every bit set: relays stay, the manual fan applies.
    send_request(make_request(OP_SETTINGS, MODE_ODD_ALL, 4'd15, 2'd3, 0));
    // Cooling from a hot room, then a relay check exactly at the setpoint.
    send_request(make_request(OP_SETTINGS, MODE_COOL, 4'd5, FAN_AUTO, 30 * 256));
    repeat (5) send_tick(21 * 256);
    send_request(make_request(OP_SETTINGS, MODE_HEAT, 4'd10, FAN_AUTO, 20 * 256 + 128));
    send_request(make_request(OP_SETTINGS, MODE_AUTO, 4'd0, FAN_AUTO, 16 * 256));
    send_request(make_request(OP_SETTINGS, MODE_AUTO, 4'd0, 2'd2, 10 * 256 + 25));
    // An unknown odd mode keeps the relay timer running but its checks change nothing.
    send_request(make_request(OP_SETTINGS, MODE_ODD_MID, 4'd3, FAN_AUTO, 5 * 256));
    repeat (5) send_tick(5 * 256);
    send_request(make_request(OP_SETTINGS, MODE_HEAT, 4'd15, 2'd1, 127 * 256 + 255));
    send_request(make_request(OP_SETTINGS, MODE_OFF_HIGH, 4'd7, 2'd2, -128));
    send_tick(0);
    wait_drained();

    // Random sessions, each phase under its own register values and one of four stall patterns.
    paused = 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: load_settings(8'd0, 8'd0, 8'd0, 8'd1);
        2: load_settings(8'd255, 8'd255, 8'd255, 8'd255);
        3: load_settings(8'd3, 8'd2, 8'd8, 8'd0);
        4: load_settings(CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 30)),
                         CfgW'($urandom_range(0, 60)), CfgW'($urandom_range(1, 12)));
        5: load_settings(CfgW'($urandom_range(0, 255)), CfgW'($urandom_range(0, 255)),
                         CfgW'($urandom_range(0, 255)), CfgW'($urandom_range(0, 6)));
        default: ;
      endcase
      rx_style = rx_style_e'(phase % 4);
      gaps_on  = (phase != 2) && (phase != 5);
      // Long hold-off on the result side while requests keep coming back to back.
      if (phase == 2) hold_len = HOLD_CYCLES;
      phase_start = n_sent;
      while (n_sent - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) send_noise($urandom_range(1, 5));
        else run_session($urandom_range(4, 60));
        // Once mid-phase in phase 4 the sender waits for every outstanding drive.
        if (phase == 4 && !paused && n_sent - phase_start > ITEMS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (6) @(posedge clk_i);
    if (sb.pending_drives.size() != 0) begin
      sb.n_failures++;
      $display("%0d predicted drives never returned", sb.pending_drives.size());
    end
    $display("summary: %0d requests (%0d settings updates, %0d ticks), %0d drive sets checked",
             n_sent, n_updates, n_ticks, sb.n_checked);
    $display("summary: %0d register settings from all zero to all ones, %0d mismatches",
             NUM_PHASES, sb.n_failures);
    if (sb.n_failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
